FILE: rtl/cpwv_pkg.sv
`default_nettype none

package cpwv_pkg;

  // tally store
  localparam int unsigned MaxSlots = 512;
  localparam int unsigned SlotW    = $clog2(MaxSlots);
  localparam int unsigned TallyW   = 32;

  // field widths
  localparam int unsigned CmdW     = 2;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned MulW     = 24;
  localparam int unsigned MbW      = 18;
  localparam int unsigned BlkW     = 4;
  localparam int unsigned LevelW   = 22;
  localparam int unsigned WeightW  = 4;
  localparam int unsigned NzW      = 7;
  localparam int unsigned PbcW     = 10;
  localparam int unsigned MinNzW   = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned SlotNumW = MbW + BlkW;

  // c*128 scaling, saturation and weight cap
  localparam int unsigned LevelShift = 7;
  localparam logic [NzW-1:0]     NzMax     = NzW'(127);
  localparam logic [WeightW-1:0] WeightCap = WeightW'(8);

  // serial divider: (|c|*128 + m) / (2m) needs 25 bits
  localparam int unsigned DivW    = 25;
  localparam int unsigned DivCntW = $clog2(DivW + 1);

  localparam logic [PbcW-1:0]   PbcReset   = PbcW'(32);
  localparam logic [MinNzW-1:0] MinNzReset = MinNzW'(2);

  typedef enum logic [CmdW-1:0] {
    CmdCoef  = 2'd0,
    CmdClear = 2'd1,
    CmdRead  = 2'd2,
    CmdNone  = 2'd3
  } cpwv_cmd_e;

  typedef enum logic [1:0] {
    OutSkip   = 2'd0,
    OutVote   = 2'd1,
    OutReport = 2'd2
  } cpwv_outcome_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPayloadBits = 2'd0,
    CfgMinNonzero  = 2'd1,
    CfgWeighted    = 2'd2
  } cpwv_cfg_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StDiv,
    StVote,
    StMod,
    StUpdate,
    StReport
  } cpwv_state_e;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] numer;
    logic [DivW-1:0] denom;
  } cpwv_div_req_t;

  typedef struct packed {
    logic            busy;
    logic [DivW-1:0] quot;
    logic [DivW-1:0] rem;
  } cpwv_div_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/coef_pair_watermark_vote.sv
// A coefficient at a pair position has its level computed by the 25-step divider; a block end then
// reduces its slot number modulo the payload bit count on the same divider, reads the tally and
// updates it; a skipped block reports once its levels are known, with no reduction; a read reports.
// One request at a time: input stalls while the bit-serial divider serves both levels and the
// slot reduction of a block, and while a result waits on a stalled output.
// Reset: asynchronous, active low; then a sweep of all 512 slots zeroes the tallies with input stalled.
`default_nettype none

module coef_pair_watermark_vote import cpwv_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CfgDataW-1:0]      cfg_data_i,

  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [CmdW-1:0]          command_i,
  input  logic signed [CoefW-1:0]  coefficient_i,
  input  logic [MulW-1:0]          multiplier_i,
  input  logic                     at_pos_a_i,
  input  logic                     at_pos_b_i,
  input  logic                     block_end_i,
  input  logic [MbW-1:0]           macroblock_index_i,
  input  logic [BlkW-1:0]          block_in_macroblock_i,
  input  logic [SlotW-1:0]         slot_to_read_i,

  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               outcome_o,
  output logic                     voted_bit_o,
  output logic [WeightW-1:0]       vote_weight_o,
  output logic [SlotW-1:0]         slot_o,
  output logic signed [LevelW-1:0] level_a_o,
  output logic signed [LevelW-1:0] level_b_o,
  output logic [TallyW-1:0]        ones_count_o,
  output logic [TallyW-1:0]        zeros_count_o
);

  cpwv_state_e state_q, state_d;

  // configuration
  logic [PbcW-1:0]   pbc_q;
  logic [MinNzW-1:0] min_nz_q;
  logic              wmode_q;

  // block state
  logic [NzW-1:0]           nz_q;
  logic signed [LevelW-1:0] held_a_q, held_b_q;

  // item held while the divider runs
  logic                pos_a_q, pos_b_q, neg_q, end_q;
  logic [SlotNumW-1:0] slot_num_q;
  logic [SlotW-1:0]    slot_q, slot_d;
  logic                slot_load;
  logic                bit_q;
  logic [WeightW-1:0]  weight_q;
  logic [SlotW-1:0]    clr_cnt_q;

  // tally memory {ones, zeros}
  logic [2*TallyW-1:0] tally_mem [MaxSlots];
  logic [2*TallyW-1:0] rdata_q;
  logic                mem_we, mem_re;
  logic [SlotW-1:0]    mem_waddr, mem_raddr;
  logic [2*TallyW-1:0] mem_wdata;

  // output register
  logic                     out_valid_q;
  cpwv_outcome_e            out_outcome_q, out_outcome_d;
  logic                     out_bit_q, out_bit_d;
  logic [WeightW-1:0]       out_weight_q, out_weight_d;
  logic [SlotW-1:0]         out_slot_q, out_slot_d;
  logic signed [LevelW-1:0] out_la_q, out_la_d, out_lb_q, out_lb_d;
  logic [TallyW-1:0]        out_ones_q, out_ones_d, out_zeros_q, out_zeros_d;
  logic                     out_load, out_free;

  cpwv_div_req_t div_req;
  cpwv_div_rsp_t div_rsp;

  logic                accept;
  logic                level_load, vote_load, block_clear;
  logic [CoefW-1:0]    coef_bits, coef_mag;
  logic [MulW-1:0]     mul_eff;
  logic [LevelW-1:0]   q_lvl, level_new;
  logic [LevelW-1:0]   abs_a, abs_b, mag_diff;
  logic                a_gt, skip;
  logic [WeightW-1:0]  weight;
  logic [PbcW-1:0]     mod_eff;
  logic [TallyW-1:0]   ones_rd, zeros_rd, ones_new, zeros_new;

  cpwv_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // level = sign(c) * floor((|c|*128 + m) / 2m); zero multiplier acts as one
  assign coef_bits = $unsigned(coefficient_i);
  assign coef_mag  = coef_bits[CoefW-1] ? (~coef_bits + CoefW'(1)) : coef_bits;
  assign mul_eff   = (multiplier_i == '0) ? MulW'(1) : multiplier_i;
  assign q_lvl     = div_rsp.quot[LevelW-1:0];
  assign level_new = neg_q ? (~q_lvl + LevelW'(1)) : q_lvl;

  always_comb begin
    abs_a    = held_a_q[LevelW-1] ? (~$unsigned(held_a_q) + LevelW'(1)) : $unsigned(held_a_q);
    abs_b    = held_b_q[LevelW-1] ? (~$unsigned(held_b_q) + LevelW'(1)) : $unsigned(held_b_q);
    a_gt     = abs_a > abs_b;
    mag_diff = a_gt ? (abs_a - abs_b) : (abs_b - abs_a);
    if (!wmode_q) begin
      weight = WeightW'(1);
    end else if (mag_diff > LevelW'(WeightCap)) begin
      weight = WeightCap;
    end else begin
      weight = mag_diff[WeightW-1:0];
    end
    skip = (NzW'(nz_q) < NzW'(min_nz_q)) || (abs_a == abs_b);
  end

  always_comb begin
    if (pbc_q == '0) begin
      mod_eff = PbcW'(1);
    end else if (pbc_q > PbcW'(MaxSlots)) begin
      mod_eff = PbcW'(MaxSlots);
    end else begin
      mod_eff = pbc_q;
    end
  end

  assign ones_rd   = rdata_q[2*TallyW-1:TallyW];
  assign zeros_rd  = rdata_q[TallyW-1:0];
  assign ones_new  = bit_q ? (ones_rd + TallyW'(weight_q)) : ones_rd;
  assign zeros_new = bit_q ? zeros_rd : (zeros_rd + TallyW'(weight_q));

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && (state_q == StIdle);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    div_req       = '0;
    mem_we        = 1'b0;
    mem_waddr     = clr_cnt_q;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = slot_to_read_i;
    slot_load     = 1'b0;
    slot_d        = slot_to_read_i;
    level_load    = 1'b0;
    vote_load     = 1'b0;
    block_clear   = 1'b0;
    out_load      = 1'b0;
    out_outcome_d = OutSkip;
    out_bit_d     = 1'b0;
    out_weight_d  = '0;
    out_slot_d    = '0;
    out_la_d      = held_a_q;
    out_lb_d      = held_b_q;
    out_ones_d    = '0;
    out_zeros_d   = '0;

    unique case (state_q)
      StClear: begin
        mem_we = 1'b1;
        if (clr_cnt_q == SlotW'(MaxSlots - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          unique case (command_i)
            CmdCoef: begin
              if (at_pos_a_i || at_pos_b_i) begin
                div_req.start = 1'b1;
                div_req.numer = DivW'({coef_mag, {LevelShift{1'b0}}}) + DivW'(mul_eff);
                div_req.denom = DivW'({mul_eff, 1'b0});
                state_d       = StDiv;
              end else if (block_end_i) begin
                state_d = StVote;
              end
            end
            CmdClear: begin
              state_d = StClear;
            end
            CmdRead: begin
              mem_re    = 1'b1;
              slot_load = 1'b1;
              state_d   = StReport;
            end
            default: ;
          endcase
        end
      end
      StDiv: begin
        if (!div_rsp.busy) begin
          level_load = 1'b1;
          state_d    = end_q ? StVote : StIdle;
        end
      end
      StVote: begin
        if (skip) begin
          if (out_free) begin
            out_load    = 1'b1;
            block_clear = 1'b1;
            state_d     = StIdle;
          end
        end else begin
          div_req.start = 1'b1;
          div_req.numer = DivW'(slot_num_q);
          div_req.denom = DivW'(mod_eff);
          vote_load     = 1'b1;
          state_d       = StMod;
        end
      end
      StMod: begin
        if (!div_rsp.busy) begin
          mem_re    = 1'b1;
          mem_raddr = div_rsp.rem[SlotW-1:0];
          slot_load = 1'b1;
          slot_d    = div_rsp.rem[SlotW-1:0];
          state_d   = StUpdate;
        end
      end
      StUpdate: begin
        if (out_free) begin
          mem_we        = 1'b1;
          mem_waddr     = slot_q;
          mem_wdata     = {ones_new, zeros_new};
          out_load      = 1'b1;
          out_outcome_d = OutVote;
          out_bit_d     = bit_q;
          out_weight_d  = weight_q;
          out_slot_d    = slot_q;
          out_ones_d    = ones_new;
          out_zeros_d   = zeros_new;
          block_clear   = 1'b1;
          state_d       = StIdle;
        end
      end
      StReport: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_outcome_d = OutReport;
          out_slot_d    = slot_q;
          out_la_d      = '0;
          out_lb_d      = '0;
          out_ones_d    = ones_rd;
          out_zeros_d   = zeros_rd;
          state_d       = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (state_q == StClear) begin
      clr_cnt_q <= clr_cnt_q + SlotW'(1);
    end else begin
      clr_cnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pbc_q    <= PbcReset;
      min_nz_q <= MinNzReset;
      wmode_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgPayloadBits: pbc_q    <= cfg_data_i[PbcW-1:0];
        CfgMinNonzero:  min_nz_q <= cfg_data_i[MinNzW-1:0];
        CfgWeighted:    wmode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nz_q     <= '0;
      held_a_q <= '0;
      held_b_q <= '0;
    end else if (block_clear) begin
      nz_q     <= '0;
      held_a_q <= '0;
      held_b_q <= '0;
    end else begin
      if (accept && (command_i == CmdCoef) && (coefficient_i != '0) && (nz_q < NzMax)) begin
        nz_q <= nz_q + NzW'(1);
      end
      if (level_load && pos_a_q) begin
        held_a_q <= $signed(level_new);
      end
      if (level_load && pos_b_q) begin
        held_b_q <= $signed(level_new);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (command_i == CmdCoef)) begin
      pos_a_q    <= at_pos_a_i;
      pos_b_q    <= at_pos_b_i;
      neg_q      <= coef_bits[CoefW-1];
      end_q      <= block_end_i;
      slot_num_q <= {macroblock_index_i, block_in_macroblock_i};
    end
    if (slot_load) begin
      slot_q <= slot_d;
    end
    if (vote_load) begin
      bit_q    <= a_gt;
      weight_q <= weight;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tally_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= tally_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_outcome_q <= out_outcome_d;
      out_bit_q     <= out_bit_d;
      out_weight_q  <= out_weight_d;
      out_slot_q    <= out_slot_d;
      out_la_q      <= out_la_d;
      out_lb_q      <= out_lb_d;
      out_ones_q    <= out_ones_d;
      out_zeros_q   <= out_zeros_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign outcome_o     = out_outcome_q;
  assign voted_bit_o   = out_bit_q;
  assign vote_weight_o = out_weight_q;
  assign slot_o        = out_slot_q;
  assign level_a_o     = out_la_q;
  assign level_b_o     = out_lb_q;
  assign ones_count_o  = out_ones_q;
  assign zeros_count_o = out_zeros_q;

endmodule

`default_nettype wire

FILE: rtl/cpwv_div.sv
`default_nettype none

module cpwv_div import cpwv_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cpwv_div_req_t req_i,
  output cpwv_div_rsp_t rsp_o
);

  logic [DivW-1:0]    rem_q, rem_d;
  logic [DivW-1:0]    quo_q;
  logic [DivW-1:0]    den_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DivW:0]      trial;
  logic [DivW:0]      diff;
  logic               qbit;

  // restoring division, one quotient bit per cycle; numerator shifts out of quo_q
  always_comb begin
    trial = {rem_q, quo_q[DivW-1]};
    diff  = trial - {1'b0, den_q};
    qbit  = ~diff[DivW];
    rem_d = qbit ? diff[DivW-1:0] : trial[DivW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (req_i.start) begin
      cnt_q <= DivCntW'(DivW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.numer;
      den_q <= req_i.denom;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DivW-2:0], qbit};
    end
  end

  assign rsp_o.busy = (cnt_q != '0);
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

FILE: rtl/cpwv_checker.sv
`default_nettype none

module cpwv_checker import cpwv_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic [CmdW-1:0]          command_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [1:0]               outcome_o,
  input logic                     voted_bit_o,
  input logic [WeightW-1:0]       vote_weight_o,
  input logic [SlotW-1:0]         slot_o,
  input logic signed [LevelW-1:0] level_a_o,
  input logic signed [LevelW-1:0] level_b_o,
  input logic [TallyW-1:0]        ones_count_o,
  input logic [TallyW-1:0]        zeros_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (command_i == CmdClear) |=> in_stall_o)
    else $error("clear request did not start a sweep");

  a_skip_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o == OutSkip) |->
      !voted_bit_o && (vote_weight_o == '0) && (slot_o == '0) &&
      (ones_count_o == '0) && (zeros_count_o == '0))
    else $error("skipped block carries vote fields");

  a_report_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o == OutReport) |->
      !voted_bit_o && (vote_weight_o == '0) && (level_a_o == '0) && (level_b_o == '0))
    else $error("tally report carries vote fields");

  a_vote_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o == OutVote) |->
      (vote_weight_o != '0) && (vote_weight_o <= WeightCap))
    else $error("vote weight out of range");

endmodule

bind coef_pair_watermark_vote cpwv_checker u_cpwv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .command_i     (command_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .outcome_o     (outcome_o),
  .voted_bit_o   (voted_bit_o),
  .vote_weight_o (vote_weight_o),
  .slot_o        (slot_o),
  .level_a_o     (level_a_o),
  .level_b_o     (level_b_o),
  .ones_count_o  (ones_count_o),
  .zeros_count_o (zeros_count_o)
);

`default_nettype wire
